// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/dptq_pkg.sv
// Types and codes for the delayed priority task queue.
// No dependencies; used by the top level, table, unit and checker files.
package dptq_pkg;

   // Command codes
   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_TICK     = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_NULL = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;
   localparam logic [1:0] STAT_NONE = 2'd3;

   localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

   // One stored task
   typedef struct packed {
      logic [15:0]        handle;
      logic [15:0]        arg;
      logic signed [15:0] prio;
   } entry_type;

   // One pending result
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_handle;
      logic [15:0] out_arg;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_SCAN,
      S_PICK,
      S_SHIFT,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/dptq_if.sv
// Request and response channel interfaces (valid/ready handshake).
// Depends on nothing else.
interface dptq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [15:0]        task_handle;
   logic [15:0]        task_arg;
   logic signed [15:0] start_priority;

   modport source (output valid, cmd, task_handle, task_arg, start_priority, input ready);
   modport sink   (input valid, cmd, task_handle, task_arg, start_priority, output ready);
endinterface

interface dptq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_handle;
   logic [15:0] out_arg;

   modport source (output valid, status, out_handle, out_arg, input ready);
   modport sink   (input valid, status, out_handle, out_arg, output ready);
endinterface

// File: hw/rtl/delayed_priority_task_queue.sv
// Delayed priority task queue. Insert goes straight to the result. Tick walks every entry and
// writes each back decremented; Dispatch scans for the minimum, checks it is ready, then shifts
// the younger entries down when the task taken is not the last one. Both answer at once when empty.
// One transaction in flight; next request is taken once the result is in the output
// register. Cost is set by one table read port walked one entry per cycle.
// Synchronous active-high reset empties the table (count zero); table data is not cleared.
module delayed_priority_task_queue #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   dptq_req_if.sink  req_chan,
   dptq_rsp_if.source rsp_chan
);
   import dptq_pkg::*;

   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic [CNTW-1:0]  rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDXW-1:0]  data_idx_ff, data_idx_in;
   entry_type        best_ff, best_in;
   logic [IDXW-1:0]  best_idx_ff, best_idx_in;
   result_type       res_ff, res_in;
   logic             rsp_vld_ff, rsp_vld_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             mem_we;
   logic [IDXW-1:0]  mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDXW-1:0]  mem_rd_addr;
   entry_type        mem_rd_data;

   logic signed [15:0] unit_a, unit_b, unit_dec;
   logic               unit_lt;

   logic more, last;

   dptq_table #(.DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dptq_unit u_unit (
      .op_a   (unit_a),
      .op_b   (unit_b),
      .a_lt_b (unit_lt),
      .a_dec  (unit_dec)
   );

   // Walk status: reads left to issue, and the entry in hand is the last live one
   assign more = rd_idx_ff < count_ff;
   assign last = (CNTW'(data_idx_ff) + CNTW'(1)) == count_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      res_in      = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;

      mem_we      = 1'b0;
      mem_wr_addr = data_idx_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_idx_ff[IDXW-1:0];

      unit_a = mem_rd_data.prio;
      unit_b = best_ff.prio;

      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_in.status     = STAT_OK;
               res_in.out_handle = '0;
               res_in.out_arg    = '0;
               rd_idx_in         = '0;
               state_in          = S_RESP;
               case (req_chan.cmd)
                  CMD_INSERT: begin
                     if (req_chan.task_handle == '0) begin
                        res_in.status = STAT_NULL;
                     end else if (count_ff == CNTW'(DEPTH)) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_we             = 1'b1;
                        mem_wr_addr        = count_ff[IDXW-1:0];
                        mem_wr_data.handle = req_chan.task_handle;
                        mem_wr_data.arg    = req_chan.task_arg;
                        mem_wr_data.prio   = req_chan.start_priority;
                        count_in           = count_ff + CNTW'(1);
                     end
                  end
                  CMD_TICK: begin
                     if (count_ff != '0) begin
                        state_in = S_TICK;
                     end
                  end
                  CMD_DISPATCH: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_NONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     res_in.status = STAT_OK;
                  end
               endcase
            end
         end

         // Read each entry, write it back decremented in the following cycle
         S_TICK: begin
            if (more) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CNTW'(1);
            end
            if (rd_vld_ff) begin
               mem_we           = 1'b1;
               mem_wr_data.prio = unit_dec;
               if (last) begin
                  state_in = S_RESP;
               end
            end
         end

         // Minimum search; strict less keeps the oldest on ties
         S_SCAN: begin
            if (more) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CNTW'(1);
            end
            if (rd_vld_ff) begin
               if (data_idx_ff == '0 || unit_lt) begin
                  best_in     = mem_rd_data;
                  best_idx_in = data_idx_ff;
               end
               if (last) begin
                  state_in = S_PICK;
               end
            end
         end

         // Ready check: zero < best means still delayed
         S_PICK: begin
            unit_a = '0;
            unit_b = best_ff.prio;
            if (unit_lt) begin
               res_in.status = STAT_NONE;
               state_in      = S_RESP;
            end else begin
               res_in.status     = STAT_OK;
               res_in.out_handle = best_ff.handle;
               res_in.out_arg    = best_ff.arg;
               if ((CNTW'(best_idx_ff) + CNTW'(1)) == count_ff) begin
                  count_in = count_ff - CNTW'(1);
                  state_in = S_RESP;
               end else begin
                  rd_idx_in = CNTW'(best_idx_ff) + CNTW'(1);
                  state_in  = S_SHIFT;
               end
            end
         end

         // Move the younger entries down one slot
         S_SHIFT: begin
            if (more) begin
               mem_rd_en = 1'b1;
               rd_idx_in = rd_idx_ff + CNTW'(1);
            end
            if (rd_vld_ff) begin
               mem_we      = 1'b1;
               mem_wr_addr = data_idx_ff - IDXW'(1);
               if (last) begin
                  count_in = count_ff - CNTW'(1);
                  state_in = S_RESP;
               end
            end
         end

         // Hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_vld_in   = mem_rd_en;
      data_idx_in = mem_rd_en ? mem_rd_addr : data_idx_ff;
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.status     = rsp_data_ff.status;
   assign rsp_chan.out_handle = rsp_data_ff.out_handle;
   assign rsp_chan.out_arg    = rsp_data_ff.out_arg;
endmodule

// File: hw/rtl/dptq_table.sv
// Task table storage: one write port, one registered read port.
// Depends on dptq_pkg for the entry type.
module dptq_table #(
   parameter int DEPTH = 16,
   localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDXW-1:0]     wr_addr,
   input  dptq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDXW-1:0]     rd_addr,
   output dptq_pkg::entry_type rd_data
);
   import dptq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/dptq_unit.sv
// Shared priority unit: signed less-than and saturating decrement.
// Depends on dptq_pkg for the minimum priority constant.
module dptq_unit (
   input  logic signed [15:0] op_a,
   input  logic signed [15:0] op_b,
   output logic               a_lt_b,
   output logic signed [15:0] a_dec
);
   import dptq_pkg::*;

   assign a_lt_b = op_a < op_b;

   // Decrement, holding at the most negative value
   assign a_dec = (op_a == PRIO_MIN) ? op_a : op_a - 16'sd1;
endmodule

// File: hw/rtl/dptq_checker.sv
// Port-level checks for the delayed priority task queue, bound to the top level.
// Depends on dptq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dptq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_out_handle,
   input logic [15:0] rsp_out_arg
);
   import dptq_pkg::*;

   // A stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_out_handle) && $stable(rsp_out_arg),
      "stalled response changed")

   // One transaction at a time: not ready right after an accept
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready,
      "request taken while busy")

   // Failed commands carry no task
   `ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid && rsp_status != STAT_OK,
      rsp_out_handle == '0 && rsp_out_arg == '0, "failed result carries task data")

   // A returned argument always comes with a real handle
   `ASSERT_IMPLIES(a_arg_has_handle, clock, reset, rsp_valid && rsp_out_arg != '0,
      rsp_out_handle != '0 && rsp_status == STAT_OK, "argument without handle")
endmodule

bind delayed_priority_task_queue dptq_checker u_dptq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_out_handle (rsp_chan.out_handle),
   .rsp_out_arg    (rsp_chan.out_arg)
);
